// ----- hw/rtl/cfdsh_pkg.sv -----
package cfdsh_pkg;

  localparam logic [31:0] MmC1 = 32'hcc9e2d51;
  localparam logic [31:0] MmC2 = 32'h1b873593;
  localparam logic [31:0] MmN  = 32'he6546b64;
  localparam logic [31:0] MmF1 = 32'h85ebca6b;
  localparam logic [31:0] MmF2 = 32'hc2b2ae35;

  typedef enum logic [1:0] {
    MUL_K_C1,
    MUL_ROT_C2,
    MUL_FMIX1,
    MUL_FMIX2
  } mul_sel_e;

  typedef struct packed {
    logic     take;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     m_body;
    logic     m_tail;
    logic     ld_k_part;
    logic     oat_fin;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] pos;
  } dp_status_t;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  function automatic logic [31:0] oat_step(input logic [31:0] h, input logic [7:0] f);
    logic [31:0] a;
    a = h + {{24{f[7]}}, f};
    a = a + (a << 10);
    a = a ^ (a >> 6);
    return a;
  endfunction

  function automatic logic [31:0] oat_final(input logic [31:0] h);
    logic [31:0] a;
    a = h + (h << 3);
    a = a ^ (a >> 11);
    a = a + (a << 15);
    if (a < 32'd2) begin
      a = a + 32'd2;
    end
    return a;
  endfunction

endpackage

// ----- hw/rtl/cfdsh_datapath.sv -----
module cfdsh_datapath
  import cfdsh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  output logic [31:0] one_at_a_time_hash_o,
  output logic [31:0] murmur_hash_o
);

  logic [31:0] oat_q, m_q, count_q, k_q, prod_q, out_oat_q, out_mm_q;
  logic [23:0] part_q;
  logic [7:0]  fold;
  logic [31:0] mul_a, mul_b, mix_x, body_h;
  logic [31:0] mul_lo;

  assign fold = fold_case(data_byte_i);
  assign status_o.pos = count_q[1:0];
  assign mix_x = m_q ^ count_q;
  assign body_h = {m_q[18:0] ^ prod_q[18:0], m_q[31:19] ^ prod_q[31:19]};

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_K_C1: begin
        mul_a = k_q;
        mul_b = MmC1;
      end
      MUL_ROT_C2: begin
        mul_a = {prod_q[16:0], prod_q[31:17]};
        mul_b = MmC2;
      end
      MUL_FMIX1: begin
        mul_a = mix_x ^ (mix_x >> 16);
        mul_b = MmF1;
      end
      MUL_FMIX2: begin
        mul_a = prod_q ^ (prod_q >> 13);
        mul_b = MmF2;
      end
      default: begin
        mul_a = k_q;
        mul_b = MmC1;
      end
    endcase
  end

  assign mul_lo = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oat_q   <= '0;
      m_q     <= '0;
      part_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.out_load) begin
      oat_q   <= '0;
      m_q     <= '0;
      part_q  <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.take && byte_present_i) begin
        oat_q   <= oat_step(oat_q, fold);
        count_q <= count_q + 32'd1;
        unique case (count_q[1:0])
          2'd0: part_q[7:0]   <= fold;
          2'd1: part_q[15:8]  <= fold;
          2'd2: part_q[23:16] <= fold;
          2'd3: part_q        <= '0;
          default: part_q     <= '0;
        endcase
      end
      if (cmd_i.oat_fin) begin
        oat_q <= oat_final(oat_q);
      end
      if (cmd_i.m_body) begin
        m_q <= (body_h << 2) + body_h + MmN;
      end else if (cmd_i.m_tail) begin
        m_q <= m_q ^ prod_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      k_q <= {fold, part_q};
    end else if (cmd_i.ld_k_part) begin
      k_q <= {8'd0, part_q};
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_lo;
    end
    if (cmd_i.out_load) begin
      out_oat_q <= oat_q;
      out_mm_q  <= prod_q ^ (prod_q >> 16);
    end
  end

  assign one_at_a_time_hash_o = out_oat_q;
  assign murmur_hash_o        = out_mm_q;

endmodule

// ----- hw/rtl/cfdsh_ctrl.sv -----
module cfdsh_ctrl
  import cfdsh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       byte_present_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MIX1 = 3'd1;
  localparam logic [2:0] S_MIX2 = 3'd2;
  localparam logic [2:0] S_MIX3 = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_FMX1 = 3'd5;
  localparam logic [2:0] S_FMX2 = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_q, state_d;
  logic       last_q, last_d, tail_q, tail_d, out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    tail_d  = tail_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_K_C1;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.take = 1'b1;
          last_d     = last_i;
          tail_d     = 1'b0;
          if (byte_present_i && status_i.pos == 2'd3) begin
            state_d = S_MIX1;
          end else if (last_i) begin
            state_d = S_FIN;
          end
        end
      end
      S_MIX1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_K_C1;
        state_d       = S_MIX2;
      end
      S_MIX2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ROT_C2;
        state_d       = S_MIX3;
      end
      S_MIX3: begin
        cmd_o.m_tail = tail_q;
        cmd_o.m_body = !tail_q;
        if (tail_q) begin
          state_d = S_FMX1;
        end else if (last_q) begin
          state_d = S_FIN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_FIN: begin
        if (status_i.pos != 2'd0) begin
          cmd_o.ld_k_part = 1'b1;
          tail_d          = 1'b1;
          state_d         = S_MIX1;
        end else begin
          state_d = S_FMX1;
        end
      end
      S_FMX1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_FMIX1;
        cmd_o.oat_fin = 1'b1;
        state_d       = S_FMX2;
      end
      S_FMX2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_FMIX2;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= 1'b0;
      tail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/case_folding_dual_string_hash_unit.sv -----
// Channel  Handshake              Beat payload
// in       in_valid_i/in_ready_o  data_byte_i, byte_present_i, last_i
// out      out_valid_o/out_ready_i one_at_a_time_hash_o, murmur_hash_o
//
// Every fourth byte beat also runs a chunk mix (two passes through
// the one shared 32x32 multiplier, then one accumulate step).
// A last beat adds finalization: FIN, a tail mix if a partial tail chunk remains,
// then FMX1, FMX2 and DONE; a chunk mix and a tail mix never fall on one beat.
// rst_ni and each result clear the running hashes, byte count and partial chunk.
// A finished result waits in the output register while new beats are taken;
// only the next finalization stalls until that result is taken.
module case_folding_dual_string_hash_unit
  import cfdsh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] one_at_a_time_hash_o,
  output logic [31:0] murmur_hash_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  cfdsh_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_present_i (byte_present_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  cfdsh_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .data_byte_i          (data_byte_i),
    .byte_present_i       (byte_present_i),
    .one_at_a_time_hash_o (one_at_a_time_hash_o),
    .murmur_hash_o        (murmur_hash_o)
  );

  a_oat_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (one_at_a_time_hash_o >= 32'd2))
    else $error("one-at-a-time result below floor");

  a_skip_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !byte_present_i && !last_i) |=> in_ready_o)
    else $error("empty non-last beat stalled input");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_i) |=> !in_ready_o)
    else $error("input taken during finalization");

endmodule
